[hw/rtl/cbf_pkg.sv]
// cbf_pkg: shared constants, types and codes of the bezier falloff curve unit
package cbf_pkg;

    localparam int MAX_HALVINGS = 24;
    localparam int FRAC_BITS    = 16;

    localparam int CTRL_W    = 18;
    localparam int X_W       = 20;
    localparam int CFG_IDX_W = 4;
    localparam int T_W       = 32;
    localparam int OP_W      = 33;
    localparam int PROD_W    = 66;
    localparam int ACC_W     = 54;
    localparam int VAL_W     = 24;
    localparam int ERR_W     = 25;
    localparam int ITER_W    = $clog2(MAX_HALVINGS);

    localparam logic [T_W-1:0] T_ONE = 32'h8000_0000;

    localparam logic signed [ACC_W:0] ROUND_BIAS = 55'sd1 <<< 30;

    localparam int TOL_INT = ((1 << FRAC_BITS) + 9999) / 10000;
    localparam logic signed [ERR_W-1:0] TOL_LSB = ERR_W'(TOL_INT);
    localparam logic signed [ERR_W-1:0] TOL_NEG = -ERR_W'(TOL_INT);

    localparam logic signed [32:0] X_ONE = 33'sd1 <<< FRAC_BITS;

    localparam logic signed [VAL_W-1:0] W_MAX = 24'sd131071;
    localparam logic signed [VAL_W-1:0] W_MIN = -24'sd131072;

    typedef logic signed [CTRL_W-1:0] ctrl_t;
    typedef logic signed [X_W-1:0]    xval_t;
    typedef logic [T_W-1:0]           tq_t;
    typedef logic signed [VAL_W-1:0]  cval_t;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_X_CTRL_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_CTRL_1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_CTRL_2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_CTRL_3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CTRL_0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CTRL_1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CTRL_2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CTRL_3 = 4'd7;

    localparam ctrl_t CTRL_RST_0 = 18'sd0;
    localparam ctrl_t CTRL_RST_1 = 18'sd21845;
    localparam ctrl_t CTRL_RST_2 = 18'sd43691;
    localparam ctrl_t CTRL_RST_3 = 18'sd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MID,
        ST_EVAL_X,
        ST_EVAL_Y,
        ST_EMIT
    } state_t;

    // one step per product; the product of each step is written back in the next
    typedef enum logic [3:0] {
        STEP_TT,
        STEP_UU,
        STEP_T2T,
        STEP_U2U,
        STEP_TU2,
        STEP_T2U,
        STEP_P0,
        STEP_P1,
        STEP_P2,
        STEP_P3,
        STEP_FIN
    } step_t;

    typedef struct packed {
        logic start;
        tq_t  t;
    } eval_req_t;

    typedef struct packed {
        logic  done;
        cval_t value;
    } eval_rsp_t;

endpackage

[hw/rtl/cbf_intf.sv]
// cbf_intf: valid/ready channel interfaces for samples, results and configuration

interface cbf_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [19:0]       x_in;

    modport source (output valid, output x_in, input ready);
    modport sink   (input valid, input x_in, output ready);
endinterface

interface cbf_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [17:0]       weight;
    logic                     converged;

    modport source (output valid, output weight, output converged, input ready);
    modport sink   (input valid, input weight, input converged, output ready);
endinterface

interface cbf_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [3:0]               index;
    logic [17:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/cbf_mul.sv]
// cbf_mul: shared signed multiplier with a registered product
module cbf_mul (
    input  logic                                clk,
    input  logic signed [cbf_pkg::OP_W-1:0]     a,
    input  logic [cbf_pkg::T_W-1:0]             b,
    output logic signed [cbf_pkg::PROD_W-1:0]   prod
);
    import cbf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * $signed({1'b0, b});
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/cbf_curve_eval.sv]
// cbf_curve_eval: sequencer evaluating one cubic bezier coordinate on the shared multiplier
module cbf_curve_eval (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cbf_pkg::eval_req_t     req,
    input  cbf_pkg::ctrl_t         pts [4],
    output cbf_pkg::eval_rsp_t     rsp
);
    import cbf_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    step_t                    step_reg;
    tq_t                      t_reg;
    tq_t                      u_reg;
    tq_t                      t2_reg;
    tq_t                      u2_reg;
    tq_t                      t3_reg;
    tq_t                      u3_reg;
    tq_t                      b1_reg;
    tq_t                      b2_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [OP_W-1:0]   a_op;
    tq_t                      b_op;
    logic signed [PROD_W-1:0] prod;
    tq_t                      prod_q;
    logic [T_W+1:0]           three_q;
    logic signed [ACC_W:0]    round_sum;

    cbf_mul u_mul (
        .clk  (clk),
        .a    (a_op),
        .b    (b_op),
        .prod (prod)
    );

    // unsigned q1.31 product back to q1.31
    assign prod_q  = prod[62:31];
    assign three_q = {2'b00, prod_q} + {1'b0, prod_q, 1'b0};

    always_comb
    begin
        a_op = '0;
        b_op = '0;
        case (step_reg)
            STEP_TT:  begin a_op = {1'b0, t_reg};  b_op = t_reg;  end
            STEP_UU:  begin a_op = {1'b0, u_reg};  b_op = u_reg;  end
            STEP_T2T: begin a_op = {1'b0, t2_reg}; b_op = t_reg;  end
            STEP_U2U: begin a_op = {1'b0, u2_reg}; b_op = u_reg;  end
            STEP_TU2: begin a_op = {1'b0, t_reg};  b_op = u2_reg; end
            STEP_T2U: begin a_op = {1'b0, t2_reg}; b_op = u_reg;  end
            STEP_P0:  begin a_op = OP_W'(pts[0]);  b_op = u3_reg; end
            STEP_P1:  begin a_op = OP_W'(pts[1]);  b_op = b1_reg; end
            STEP_P2:  begin a_op = OP_W'(pts[2]);  b_op = b2_reg; end
            STEP_P3:  begin a_op = OP_W'(pts[3]);  b_op = t3_reg; end
            default:  begin a_op = '0;             b_op = '0;     end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_TT;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_FIN);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_TT;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_FIN)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_t'(step_reg + 4'd1);
                end
            end
        end
    end

    // load t and u = 1 - t on a start, else write back the product of the step before
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            t_reg <= req.t;
            u_reg <= T_ONE - req.t;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                STEP_UU:  t2_reg  <= prod_q;
                STEP_T2T: u2_reg  <= prod_q;
                STEP_U2U: t3_reg  <= prod_q;
                STEP_TU2: u3_reg  <= prod_q;
                STEP_T2U: b1_reg  <= three_q[T_W-1:0];
                STEP_P0:  b2_reg  <= three_q[T_W-1:0];
                STEP_P1:  acc_reg <= prod[ACC_W-1:0];
                STEP_P2, STEP_P3, STEP_FIN:
                          acc_reg <= acc_reg + prod[ACC_W-1:0];
                default:  ;
            endcase
        end
    end

    // round half up, then floor shift by 31
    assign round_sum = {acc_reg[ACC_W-1], acc_reg} + ROUND_BIAS;

    assign rsp.done  = done_reg;
    assign rsp.value = round_sum[ACC_W:31];

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("evaluation started while the sequencer is busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("evaluation done held for more than one cycle");
`endif

endmodule

[hw/rtl/cubic_bezier_falloff_curve_unit.sv]
// cubic_bezier_falloff_curve_unit: bisection solver for a bezier falloff curve y(x)
// a clamped sample skips the bisection, else the t interval is halved at most MAX_HALVINGS
// times before the y evaluation and output; one sample at a time, a new one is taken
// only once the last result has been loaded into the output register; ten products per
// curve evaluation on the shared multiplier
// reset: asynchronous active low, clears control state and restores control points
module cubic_bezier_falloff_curve_unit (
    input  logic       clk,
    input  logic       rst_n,
    cbf_in_if.sink     sample,
    cbf_out_if.source  result,
    cbf_cfg_if.sink    cfg
);
    import cbf_pkg::*;

    state_t             state_reg;
    state_t             state_next;

    ctrl_t              x_ctrl_reg [4];
    ctrl_t              y_ctrl_reg [4];
    ctrl_t              pts [4];

    xval_t              x_reg,     x_next;
    tq_t                lo_reg,    lo_next;
    tq_t                hi_reg,    hi_next;
    tq_t                mid_reg,   mid_next;
    logic [ITER_W-1:0]  iter_reg,  iter_next;
    ctrl_t              res_w_reg, res_w_next;
    logic               conv_reg,  conv_next;

    logic               out_valid_reg, out_valid_next;
    ctrl_t              out_w_reg,     out_w_next;
    logic               out_c_reg,     out_c_next;

    eval_req_t          req;
    eval_rsp_t          rsp;

    logic               accept;
    logic               x_low;
    logic               x_high;
    logic [T_W:0]       mid_sum;
    logic signed [ERR_W-1:0] err;
    logic               err_high;
    logic               err_low;
    logic               hit;
    logic               cap;
    logic               out_free;
    ctrl_t              w_sat;

    assign accept = sample.valid && sample.ready;
    assign x_low  = sample.x_in[X_W-1] || (sample.x_in == '0);
    assign x_high = $signed({{(33-X_W){sample.x_in[X_W-1]}}, sample.x_in}) >= X_ONE;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    assign err = $signed({rsp.value[VAL_W-1], rsp.value})
               - $signed({{(ERR_W-X_W){x_reg[X_W-1]}}, x_reg});
    assign err_high = err > TOL_LSB;
    assign err_low  = err < TOL_NEG;
    assign hit      = !err_high && !err_low;
    assign cap      = iter_reg == ITER_W'(MAX_HALVINGS - 1);

    always_comb
    begin
        if (rsp.value > W_MAX)
        begin
            w_sat = W_MAX[CTRL_W-1:0];
        end
        else if (rsp.value < W_MIN)
        begin
            w_sat = W_MIN[CTRL_W-1:0];
        end
        else
        begin
            w_sat = rsp.value[CTRL_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    // x polygon while bisecting, y polygon for the final value
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pts[i] = (state_reg == ST_EVAL_Y) ? y_ctrl_reg[i] : x_ctrl_reg[i];
        end
    end

    cbf_curve_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pts   (pts),
        .rsp   (rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (x_low || x_high) ? ST_EMIT : ST_MID;
                end
            end
            ST_MID:
            begin
                state_next = ST_EVAL_X;
            end
            ST_EVAL_X:
            begin
                if (rsp.done)
                begin
                    state_next = (hit || cap) ? ST_EVAL_Y : ST_MID;
                end
            end
            ST_EVAL_Y:
            begin
                if (rsp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        x_next         = x_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        iter_next      = iter_reg;
        res_w_next     = res_w_reg;
        conv_next      = conv_reg;
        out_w_next     = out_w_reg;
        out_c_next     = out_c_reg;
        out_valid_next = out_valid_reg && !result.ready;
        req.start      = 1'b0;
        req.t          = mid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next    = sample.x_in;
                    lo_next   = '0;
                    hi_next   = T_ONE;
                    iter_next = '0;
                    conv_next = 1'b1;
                    res_w_next = x_low ? y_ctrl_reg[0] : y_ctrl_reg[3];
                end
            end
            ST_MID:
            begin
                mid_next  = mid_sum[T_W:1];
                req.start = 1'b1;
                req.t     = mid_sum[T_W:1];
            end
            ST_EVAL_X:
            begin
                if (rsp.done)
                begin
                    iter_next = iter_reg + 1'b1;
                    if (err_high)
                    begin
                        hi_next = mid_reg;
                    end
                    else if (err_low)
                    begin
                        lo_next = mid_reg;
                    end
                    if (hit || cap)
                    begin
                        conv_next = hit;
                        req.start = 1'b1;
                    end
                end
            end
            ST_EVAL_Y:
            begin
                if (rsp.done)
                begin
                    res_w_next = w_sat;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_w_next     = res_w_reg;
                    out_c_next     = conv_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        res_w_reg <= res_w_next;
        conv_reg  <= conv_next;
        out_w_reg <= out_w_next;
        out_c_reg <= out_c_next;
    end

    // control point registers, unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_ctrl_reg[0] <= CTRL_RST_0;
            x_ctrl_reg[1] <= CTRL_RST_1;
            x_ctrl_reg[2] <= CTRL_RST_2;
            x_ctrl_reg[3] <= CTRL_RST_3;
            y_ctrl_reg[0] <= CTRL_RST_0;
            y_ctrl_reg[1] <= CTRL_RST_1;
            y_ctrl_reg[2] <= CTRL_RST_2;
            y_ctrl_reg[3] <= CTRL_RST_3;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_X_CTRL_0: x_ctrl_reg[0] <= $signed(cfg.data);
                REG_X_CTRL_1: x_ctrl_reg[1] <= $signed(cfg.data);
                REG_X_CTRL_2: x_ctrl_reg[2] <= $signed(cfg.data);
                REG_X_CTRL_3: x_ctrl_reg[3] <= $signed(cfg.data);
                REG_Y_CTRL_0: y_ctrl_reg[0] <= $signed(cfg.data);
                REG_Y_CTRL_1: y_ctrl_reg[1] <= $signed(cfg.data);
                REG_Y_CTRL_2: y_ctrl_reg[2] <= $signed(cfg.data);
                REG_Y_CTRL_3: y_ctrl_reg[3] <= $signed(cfg.data);
                default: ;
            endcase
        end
    end

    assign cfg.ready        = 1'b1;
    assign sample.ready     = (state_reg == ST_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.weight    = out_w_reg;
    assign result.converged = out_c_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("sample transaction did not start processing");

    a_done_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == ST_EVAL_X || state_reg == ST_EVAL_Y))
        else $error("curve evaluation finished outside an evaluation state");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=> out_valid_reg)
        else $error("result not presented after leaving the emit state");
`endif

endmodule
